[rtl/core/fresnel_conductor_reflectance_top_macros.svh]
// Assertion macros for the Fresnel conductor reflectance block
`ifndef FRESNEL_CONDUCTOR_REFLECTANCE_TOP_MACROS_SVH
`define FRESNEL_CONDUCTOR_REFLECTANCE_TOP_MACROS_SVH

// Plain property, checked at every edge outside reset
`define FCR_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication
`define FCR_IMPLIES(label, ante, cons, msg) \
    `FCR_CHECK(label, (ante) |-> (cons), msg)

`endif

[rtl/core/fcr_pkg.sv]
// Types, constants and iteration steps for the Fresnel conductor reflectance pipeline
`timescale 1ns / 1ps

package fcr_pkg;

    localparam logic [16:0] Q_ONE     = 17'h10000;
    localparam logic [21:0] RATIO_MAX = 22'h3FFFFF;

    // iterative sections, two result bits per stage
    localparam int RDIV_STAGES = 11;  // 22-bit index ratio quotients
    localparam int SQ1_STAGES  = 15;  // 30-bit root of a 60-bit radicand
    localparam int SQ2_STAGES  = 12;  // 24-bit root of a 48-bit radicand
    localparam int DIV_STAGES  = 9;   // 18-bit quotients for Rs and Rp

    localparam int LATENCY = (RDIV_STAGES + 1) + 3 + (SQ1_STAGES + 1) + (SQ2_STAGES + 1)
                           + 3 + (DIV_STAGES + 1) + 1 + (DIV_STAGES + 1) + 1;

    typedef struct packed {
        logic [16:0] c;
        logic [16:0] c2;
        logic [16:0] s2;
        logic        deg;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [15:0] ei;
        logic [15:0] e_rem;
        logic [21:0] e_lq;
        logic        e_ovf;
        logic [15:0] k_rem;
        logic [21:0] k_lq;
        logic        k_ovf;
    } rdiv_t;

    typedef struct packed {
        side_t       side;
        logic [43:0] eta2_p;
        logic [43:0] etak2_p;
        logic [43:0] x_p;
    } mul1_t;

    typedef struct packed {
        side_t       side;
        logic [29:0] t0;
        logic [28:0] mag;
        logic [29:0] x2;
    } m2_t;

    typedef struct packed {
        side_t       side;
        logic [29:0] t0;
        logic [57:0] mag_sq;
        logic [59:0] x2_sq;
    } m3_t;

    typedef struct packed {
        side_t       side;
        logic [29:0] t0;
        logic [31:0] rem;
        logic [29:0] root;
        logic [59:0] rad;
    } sq1_t;

    typedef struct packed {
        side_t       side;
        logic [29:0] ab;
        logic [30:0] t1;
        logic [25:0] rem;
        logic [23:0] root;
        logic [47:0] rad;
    } sq2_t;

    typedef struct packed {
        side_t       side;
        logic [30:0] t1;
        logic [40:0] ca;
        logic [46:0] c2ab;
        logic [33:0] s2s2;
    } q1_t;

    typedef struct packed {
        side_t       side;
        logic [25:0] t2;
        logic [31:0] t3;
        logic [30:0] num;
        logic [31:0] den;
    } q2_t;

    typedef struct packed {
        side_t       side;
        logic [31:0] t3;
        logic [30:0] num;
        logic [31:0] den;
        logic [42:0] t2s2;
    } q3_t;

    typedef struct packed {
        logic [31:0] den;
        logic [31:0] rem;
        logic [17:0] lq;
    } dv_core_t;

    typedef struct packed {
        side_t       side;
        dv_core_t    dv;
        logic [31:0] num2;
        logic [31:0] den2;
    } rsd_t;

    typedef struct packed {
        side_t       side;
        logic [16:0] rs;
        logic [48:0] prod;
        logic [31:0] den2;
    } r1_t;

    typedef struct packed {
        side_t       side;
        dv_core_t    dv;
        logic [16:0] rs;
    } rpd_t;

    // Two restoring division steps on both ratio lanes
    function automatic rdiv_t rdiv_step(rdiv_t s);
        rdiv_t       r;
        logic [16:0] te;
        logic [16:0] tk;
        logic [16:0] de;
        logic [16:0] dk;
        r = s;
        for (int i = 0; i < 2; i++) begin
            te = {r.e_rem, r.e_lq[21]};
            de = te - {1'b0, r.ei};
            if (te >= {1'b0, r.ei}) begin
                r.e_rem = de[15:0];
                r.e_lq  = {r.e_lq[20:0], 1'b1};
            end else begin
                r.e_rem = te[15:0];
                r.e_lq  = {r.e_lq[20:0], 1'b0};
            end
            tk = {r.k_rem, r.k_lq[21]};
            dk = tk - {1'b0, r.ei};
            if (tk >= {1'b0, r.ei}) begin
                r.k_rem = dk[15:0];
                r.k_lq  = {r.k_lq[20:0], 1'b1};
            end else begin
                r.k_rem = tk[15:0];
                r.k_lq  = {r.k_lq[20:0], 1'b0};
            end
        end
        return r;
    endfunction

    // Two digit-by-digit square root steps, 60-bit radicand
    function automatic sq1_t sq1_step(sq1_t s);
        sq1_t        r;
        logic [33:0] tmp;
        logic [33:0] tst;
        logic [33:0] dif;
        r = s;
        for (int i = 0; i < 2; i++) begin
            tmp = {r.rem, r.rad[59:58]};
            tst = {2'b00, r.root, 2'b01};
            dif = tmp - tst;
            if (tmp >= tst) begin
                r.rem  = dif[31:0];
                r.root = {r.root[28:0], 1'b1};
            end else begin
                r.rem  = tmp[31:0];
                r.root = {r.root[28:0], 1'b0};
            end
            r.rad = {r.rad[57:0], 2'b00};
        end
        return r;
    endfunction

    // Two digit-by-digit square root steps, 48-bit radicand
    function automatic sq2_t sq2_step(sq2_t s);
        sq2_t        r;
        logic [27:0] tmp;
        logic [27:0] tst;
        logic [27:0] dif;
        r = s;
        for (int i = 0; i < 2; i++) begin
            tmp = {r.rem, r.rad[47:46]};
            tst = {2'b00, r.root, 2'b01};
            dif = tmp - tst;
            if (tmp >= tst) begin
                r.rem  = dif[25:0];
                r.root = {r.root[22:0], 1'b1};
            end else begin
                r.rem  = tmp[25:0];
                r.root = {r.root[22:0], 1'b0};
            end
            r.rad = {r.rad[45:0], 2'b00};
        end
        return r;
    endfunction

    // Two restoring division steps, 32-bit divisor
    function automatic dv_core_t dv_step(dv_core_t s);
        dv_core_t    r;
        logic [32:0] tmp;
        logic [32:0] dif;
        r = s;
        for (int i = 0; i < 2; i++) begin
            tmp = {r.rem, r.lq[17]};
            dif = tmp - {1'b0, r.den};
            if (tmp >= {1'b0, r.den}) begin
                r.rem = dif[31:0];
                r.lq  = {r.lq[16:0], 1'b1};
            end else begin
                r.rem = tmp[31:0];
                r.lq  = {r.lq[16:0], 1'b0};
            end
        end
        return r;
    endfunction

    // Rs divider stage: payload passes, quotient advances
    function automatic rsd_t rsd_step(rsd_t s);
        rsd_t r;
        r    = s;
        r.dv = dv_step(s.dv);
        return r;
    endfunction

    // Rp divider stage: payload passes, quotient advances
    function automatic rpd_t rpd_step(rpd_t s);
        rpd_t r;
        r    = s;
        r.dv = dv_step(s.dv);
        return r;
    endfunction

endpackage

[rtl/core/fresnel_conductor_reflectance_top.sv]
// Pipelined unpolarized Fresnel reflectance of a conductor, fixed point
//
//  channel   dir  handshake           payload
//  command   in   start, busy         cos_incident, eta_incident, eta_transmit, absorption_k
//  result    out  done (1-cycle)      reflectance, degenerate
//
// One transfer per cycle in, one per cycle out; busy is always low.
// The pipeline depth, LATENCY in fcr_pkg, is set mostly by the bit-serial stages of the
// ratio dividers, the two square roots and the Rs and Rp dividers.
// Reset clears the valid chain only; items in flight are dropped.
// The receiver cannot stall, so the pipeline advances every cycle.
`timescale 1ns / 1ps

module fresnel_conductor_reflectance_top
    import fcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [16:0] cos_incident,
    input  logic [15:0] eta_incident,
    input  logic [15:0] eta_transmit,
    input  logic [15:0] absorption_k,
    output logic        done,
    output logic [16:0] reflectance,
    output logic        degenerate
);

    `include "fresnel_conductor_reflectance_top_macros.svh"

    logic [LATENCY-1:0] vld_reg;
    logic [LATENCY-1:0] vld_next;

    rdiv_t    rdiv_reg [0:RDIV_STAGES];
    rdiv_t    rdiv_next;
    mul1_t    mul1_reg;
    mul1_t    mul1_next;
    m2_t      m2_reg;
    m2_t      m2_next;
    m3_t      m3_reg;
    m3_t      m3_next;
    sq1_t     sq1_reg [0:SQ1_STAGES];
    sq1_t     sq1_next;
    sq2_t     sq2_reg [0:SQ2_STAGES];
    sq2_t     sq2_next;
    q1_t      q1_reg;
    q1_t      q1_next;
    q2_t      q2_reg;
    q2_t      q2_next;
    q3_t      q3_reg;
    q3_t      q3_next;
    rsd_t     rsd_reg [0:DIV_STAGES];
    rsd_t     rsd_next;
    r1_t      r1_reg;
    r1_t      r1_next;
    rpd_t     rpd_reg [0:DIV_STAGES];
    rpd_t     rpd_next;
    logic [16:0] refl_reg;
    logic [16:0] refl_next;
    logic        deg_reg;
    logic        deg_next;

    assign busy        = 1'b0;
    assign done        = vld_reg[LATENCY-1];
    assign reflectance = refl_reg;
    assign degenerate  = deg_reg;

    assign vld_next = {vld_reg[LATENCY-2:0], start};

    // entry: clamp cosine, c^2, ratio dividends and overflow check
    always_comb begin
        logic [16:0] c;
        logic [33:0] cc;
        logic [33:0] ccr;
        logic [32:0] ne;
        logic [32:0] nk;
        c   = (cos_incident > Q_ONE) ? Q_ONE : cos_incident;
        cc  = c * c;
        ccr = cc + 34'h8000;
        ne  = {1'b0, eta_transmit, 16'h0000} + {18'h0, eta_incident[15:1]};
        nk  = {1'b0, absorption_k, 16'h0000} + {18'h0, eta_incident[15:1]};
        rdiv_next.side.c   = c;
        rdiv_next.side.c2  = ccr[32:16];
        rdiv_next.side.s2  = Q_ONE - ccr[32:16];
        rdiv_next.side.deg = (eta_incident == 16'h0000);
        rdiv_next.ei       = eta_incident;
        rdiv_next.e_ovf    = ({5'b0, ne[32:22]} >= eta_incident);
        rdiv_next.e_rem    = rdiv_next.e_ovf ? 16'h0000 : {5'b0, ne[32:22]};
        rdiv_next.e_lq     = ne[21:0];
        rdiv_next.k_ovf    = ({5'b0, nk[32:22]} >= eta_incident);
        rdiv_next.k_rem    = rdiv_next.k_ovf ? 16'h0000 : {5'b0, nk[32:22]};
        rdiv_next.k_lq     = nk[21:0];
    end

    // relative indices and their products
    always_comb begin
        logic [21:0] eta;
        logic [21:0] etak;
        eta  = rdiv_reg[RDIV_STAGES].e_ovf ? RATIO_MAX : rdiv_reg[RDIV_STAGES].e_lq;
        etak = rdiv_reg[RDIV_STAGES].k_ovf ? RATIO_MAX : rdiv_reg[RDIV_STAGES].k_lq;
        mul1_next.side    = rdiv_reg[RDIV_STAGES].side;
        mul1_next.eta2_p  = eta * eta;
        mul1_next.etak2_p = etak * etak;
        mul1_next.x_p     = eta * etak;
    end

    // t0 = eta^2 - k^2 - sin^2, its magnitude, and 2x
    always_comb begin
        logic [44:0] e2;
        logic [44:0] k2;
        logic [44:0] xr;
        logic [30:0] t0w;
        logic [30:0] t0n;
        e2  = {1'b0, mul1_reg.eta2_p} + 45'h8000;
        k2  = {1'b0, mul1_reg.etak2_p} + 45'h8000;
        xr  = {1'b0, mul1_reg.x_p} + 45'h8000;
        t0w = {2'b00, e2[44:16]} - {2'b00, k2[44:16]} - {14'h0, mul1_reg.side.s2};
        t0n = 31'h0 - t0w;
        m2_next.side = mul1_reg.side;
        m2_next.t0   = t0w[29:0];
        m2_next.mag  = t0w[30] ? t0n[28:0] : t0w[28:0];
        m2_next.x2   = {xr[44:16], 1'b0};
    end

    always_comb begin
        m3_next.side   = m2_reg.side;
        m3_next.t0     = m2_reg.t0;
        m3_next.mag_sq = m2_reg.mag * m2_reg.mag;
        m3_next.x2_sq  = m2_reg.x2 * m2_reg.x2;
    end

    always_comb begin
        sq1_next.side = m3_reg.side;
        sq1_next.t0   = m3_reg.t0;
        sq1_next.rem  = 32'h0;
        sq1_next.root = 30'h0;
        sq1_next.rad  = {2'b00, m3_reg.mag_sq} + m3_reg.x2_sq;
    end

    // ab from the first root; radicand of the second is max(ab + t0, 0) / 2
    always_comb begin
        logic [29:0] ab;
        logic [31:0] sum;
        logic [30:0] sumc;
        ab   = sq1_reg[SQ1_STAGES].root;
        sum  = {2'b00, ab} + {{2{sq1_reg[SQ1_STAGES].t0[29]}}, sq1_reg[SQ1_STAGES].t0};
        sumc = sum[31] ? 31'h0 : sum[30:0];
        sq2_next.side = sq1_reg[SQ1_STAGES].side;
        sq2_next.ab   = ab;
        sq2_next.t1   = {1'b0, ab} + {14'h0, sq1_reg[SQ1_STAGES].side.c2};
        sq2_next.rem  = 26'h0;
        sq2_next.root = 24'h0;
        sq2_next.rad  = {2'b00, sumc, 15'h0000};
    end

    always_comb begin
        q1_next.side = sq2_reg[SQ2_STAGES].side;
        q1_next.t1   = sq2_reg[SQ2_STAGES].t1;
        q1_next.ca   = sq2_reg[SQ2_STAGES].side.c * sq2_reg[SQ2_STAGES].root;
        q1_next.c2ab = sq2_reg[SQ2_STAGES].side.c2 * sq2_reg[SQ2_STAGES].ab;
        q1_next.s2s2 = sq2_reg[SQ2_STAGES].side.s2 * sq2_reg[SQ2_STAGES].side.s2;
    end

    // t2, t3 and the Rs numerator and denominator
    always_comb begin
        logic [41:0] t2w;
        logic [47:0] c2abr;
        logic [34:0] s2s2r;
        logic [30:0] t2x;
        t2w   = {q1_reg.ca, 1'b0} + 42'h8000;
        c2abr = {1'b0, q1_reg.c2ab} + 48'h8000;
        s2s2r = {1'b0, q1_reg.s2s2} + 35'h8000;
        t2x   = {5'b0, t2w[41:16]};
        q2_next.side = q1_reg.side;
        q2_next.t2   = t2w[41:16];
        q2_next.t3   = c2abr[47:16] + {13'h0, s2s2r[34:16]};
        q2_next.num  = (q1_reg.t1 > t2x) ? (q1_reg.t1 - t2x) : 31'h0;
        q2_next.den  = {1'b0, q1_reg.t1} + {6'h0, q2_next.t2};
    end

    always_comb begin
        q3_next.side = q2_reg.side;
        q3_next.t3   = q2_reg.t3;
        q3_next.num  = q2_reg.num;
        q3_next.den  = q2_reg.den;
        q3_next.t2s2 = q2_reg.t2 * q2_reg.side.s2;
    end

    // t4, the Rp operands, and the rounded Rs dividend
    always_comb begin
        logic [43:0] t4w;
        logic [31:0] t4;
        logic [32:0] d2;
        logic [48:0] dvd;
        t4w = {1'b0, q3_reg.t2s2} + 44'h8000;
        t4  = {4'h0, t4w[43:16]};
        d2  = {1'b0, q3_reg.t3} + {1'b0, t4};
        dvd = {2'b00, q3_reg.num, 16'h0000} + {18'h0, q3_reg.den[31:1]};
        rsd_next.side     = q3_reg.side;
        rsd_next.side.deg = q3_reg.side.deg || (q3_reg.den == 32'h0) || (d2[31:0] == 32'h0);
        rsd_next.num2     = (q3_reg.t3 > t4) ? (q3_reg.t3 - t4) : 32'h0;
        rsd_next.den2     = d2[31:0];
        rsd_next.dv.den   = q3_reg.den;
        rsd_next.dv.rem   = {1'b0, dvd[48:18]};
        rsd_next.dv.lq    = dvd[17:0];
    end

    always_comb begin
        logic [16:0] rs;
        rs = (rsd_reg[DIV_STAGES].dv.lq > {1'b0, Q_ONE}) ? Q_ONE
                                                        : rsd_reg[DIV_STAGES].dv.lq[16:0];
        r1_next.side = rsd_reg[DIV_STAGES].side;
        r1_next.rs   = rs;
        r1_next.prod = rs * rsd_reg[DIV_STAGES].num2;
        r1_next.den2 = rsd_reg[DIV_STAGES].den2;
    end

    always_comb begin
        logic [49:0] dvd;
        dvd = {1'b0, r1_reg.prod} + {19'h0, r1_reg.den2[31:1]};
        rpd_next.side   = r1_reg.side;
        rpd_next.rs     = r1_reg.rs;
        rpd_next.dv.den = r1_reg.den2;
        rpd_next.dv.rem = dvd[49:18];
        rpd_next.dv.lq  = dvd[17:0];
    end

    // average of Rs and Rp, forced to one on a zero incident index or a zero denominator
    always_comb begin
        logic [17:0] avg;
        avg = {1'b0, rpd_reg[DIV_STAGES].rs} + {1'b0, rpd_reg[DIV_STAGES].dv.lq[16:0]} + 18'd1;
        deg_next  = rpd_reg[DIV_STAGES].side.deg;
        refl_next = deg_next ? Q_ONE : avg[17:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rdiv_reg[0] <= rdiv_next;
        for (int i = 1; i <= RDIV_STAGES; i++)
        begin
            rdiv_reg[i] <= rdiv_step(rdiv_reg[i-1]);
        end
        mul1_reg   <= mul1_next;
        m2_reg     <= m2_next;
        m3_reg     <= m3_next;
        sq1_reg[0] <= sq1_next;
        for (int i = 1; i <= SQ1_STAGES; i++)
        begin
            sq1_reg[i] <= sq1_step(sq1_reg[i-1]);
        end
        sq2_reg[0] <= sq2_next;
        for (int i = 1; i <= SQ2_STAGES; i++)
        begin
            sq2_reg[i] <= sq2_step(sq2_reg[i-1]);
        end
        q1_reg     <= q1_next;
        q2_reg     <= q2_next;
        q3_reg     <= q3_next;
        rsd_reg[0] <= rsd_next;
        for (int i = 1; i <= DIV_STAGES; i++)
        begin
            rsd_reg[i] <= rsd_step(rsd_reg[i-1]);
        end
        r1_reg     <= r1_next;
        rpd_reg[0] <= rpd_next;
        for (int i = 1; i <= DIV_STAGES; i++)
        begin
            rpd_reg[i] <= rpd_step(rpd_reg[i-1]);
        end
        refl_reg <= refl_next;
        deg_reg  <= deg_next;
    end

    `FCR_IMPLIES(a_refl_range, done, reflectance <= Q_ONE, "reflectance above one")
    `FCR_IMPLIES(a_deg_one, done && degenerate, reflectance == Q_ONE, "degenerate result not one")
    `FCR_IMPLIES(a_zero_index, done && ($past(eta_incident, LATENCY) == 16'h0000), degenerate, "zero incident index not flagged")

endmodule
